// File: hdl/olr_pkg.sv
// ----------------------------------------------------------------------------
// olr_pkg
// Shared types and constants for the open-loop three-phase startup ramp.
// ----------------------------------------------------------------------------
package olr_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AMP_MUL,
    S_AMP_SUM,
    S_SIN_RD,
    S_SIN_MUL,
    S_SIN_SCALE,
    S_VEL_MUL,
    S_VEL_UPD,
    S_PH_MUL1,
    S_PH_MUL2,
    S_PH_MUL3,
    S_PH_ADD,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    CFG_MAX_AMPLITUDE   = 3'd0,
    CFG_AMPLITUDE_STEP  = 3'd1,
    CFG_TOP_VELOCITY    = 3'd2,
    CFG_VELOCITY_GROWTH = 3'd3,
    CFG_WRAP_DT         = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DUTY_W     = 17;

  localparam logic [31:0] PHASE_GAIN = 32'd44798134;
  localparam logic [31:0] THIRD_TURN = 32'h5555_5555;
  localparam logic [16:0] DUTY_MAX   = 17'h1_FFFF;

  localparam logic [31:0] MAX_AMPLITUDE_RST   = 32'd3006477107;
  localparam logic [15:0] AMPLITUDE_STEP_RST  = 16'd601;
  localparam logic [30:0] TOP_VELOCITY_RST    = 31'd1048576000;
  localparam logic [16:0] VELOCITY_GROWTH_RST = 17'd65733;
  localparam logic [15:0] WRAP_DT_RST         = 16'd180;
  localparam logic [31:0] VELOCITY_RST        = 32'd314573;

endpackage

// File: hdl/olr_if.sv
// ----------------------------------------------------------------------------
// olr_if
// Valid/ready channels for timestamp beats in and duty beats out.
// ----------------------------------------------------------------------------
interface olr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_us;
  logic        hold;

  modport source (output valid, output now_us, output hold, input ready);
  modport sink   (input valid, input now_us, input hold, output ready);
endinterface

interface olr_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] duty_u;
  logic [16:0] duty_v;
  logic [16:0] duty_w;

  modport source (output valid, output duty_u, output duty_v, output duty_w, input ready);
  modport sink   (input valid, input duty_u, input duty_v, input duty_w, output ready);
endinterface

// File: hdl/olr_mul.sv
// ----------------------------------------------------------------------------
// olr_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module olr_mul (
  input  logic             clk,
  input  olr_pkg::mul_req_t req,
  output logic [63:0]      p
);

  logic [63:0] p_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      p_r <= 64'(req.a) * 64'(req.b);
    end
  end

  assign p = p_r;

endmodule

// File: hdl/olr_sine_rom.sv
// ----------------------------------------------------------------------------
// olr_sine_rom
// Quarter-wave sine table with quadrant folding; returns sine + 1.0 in Q2.15.
// ----------------------------------------------------------------------------
module olr_sine_rom #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic [31:0] phase,
  output logic [16:0] biased
);

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PROD_W = 30 + IDX_W;
  localparam logic [IDX_W-1:0] DEPTH_K = IDX_W'(SINE_TABLE_DEPTH);
  localparam longint Q30 = 64'sd1073741824;

  typedef logic [15:0] tab_t [0:SINE_TABLE_DEPTH];

  function automatic logic [15:0] quarter_sine(int k);
    longint t;
    longint s;
    longint r;
    t = (longint'(k) <<< 30) / SINE_TABLE_DEPTH;
    s = (t * t) / Q30;
    r = -64'sd3864;
    r = 64'sd172270 + (r * s) / Q30;
    r = -64'sd5026990 + (r * s) / Q30;
    r = 64'sd85569310 + (r * s) / Q30;
    r = -64'sd693598670 + (r * s) / Q30;
    r = 64'sd1686629713 + (r * s) / Q30;
    r = (r * t) / Q30;
    if (r < 0) begin
      r = 0;
    end
    r = (r + 64'sd16384) / 64'sd32768;
    if (r > 64'sd32768) begin
      r = 64'sd32768;
    end
    return r[15:0];
  endfunction

  function automatic tab_t build_tab();
    tab_t tab;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      tab[k] = quarter_sine(k);
    end
    return tab;
  endfunction

  localparam tab_t SINE_TAB = build_tab();

  logic [PROD_W-1:0] idx_prod;
  logic [IDX_W-1:0]  idx_i;
  logic [IDX_W-1:0]  idx_k;
  logic [15:0]       mag_r;
  logic              neg_r;

  assign idx_prod = PROD_W'(phase[29:0]) * PROD_W'(SINE_TABLE_DEPTH);
  assign idx_i    = idx_prod[PROD_W-1:30];
  assign idx_k    = phase[30] ? DEPTH_K - idx_i : idx_i;

  always_ff @(posedge clk) begin
    mag_r <= SINE_TAB[idx_k];
    neg_r <= phase[31];
  end

  assign biased = neg_r ? 17'd32768 - 17'(mag_r) : 17'd32768 + 17'(mag_r);

endmodule

// File: hdl/open_loop_three_phase_ramp.sv
// ----------------------------------------------------------------------------
// open_loop_three_phase_ramp
// Open-loop motor startup: ramps amplitude, speed and phase from timestamps
// and emits three sine duty commands per update.
// ----------------------------------------------------------------------------
// in_bus carries one beat per update: now_us (microsecond timestamp) and hold.
// out_bus returns one beat per input with duty_u, duty_v, duty_w in Q3.14.
// cfg_we/cfg_index/cfg_wdata write the five ramp registers; the user must
// write them only while idle, as the block itself does not enforce it.
// One shared 32x32 multiplier under a small sequencer does all products:
// amplitude step, three sine scalings, speed growth and three phase-step
// products. The growth step is skipped once the speed has reached its
// target. A new input beat is taken only in idle, after the sequencer has
// finished the previous one. The duties sit in an output register; in_bus
// accepts the next beat while a result waits, and the sequencer stalls in
// its last step until out_bus takes the previous beat.
// Synchronous reset loads register defaults, clears last time, amplitude
// and phase, sets speed to 0.3 rad/s and drops out_bus.valid.
// ----------------------------------------------------------------------------
module open_loop_three_phase_ramp #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  olr_in_if.sink                           in_bus,
  olr_out_if.source                        out_bus,
  input  logic                             cfg_we,
  input  logic [olr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [olr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  olr_pkg::state_t state_r, state_nxt;

  logic [31:0] max_amp_r;
  logic [15:0] amp_step_r;
  logic [30:0] top_vel_r;
  logic [16:0] vel_growth_r;
  logic [15:0] wrap_dt_r;

  logic [31:0] last_time_r, last_time_nxt;
  logic [31:0] amp_r, amp_nxt;
  logic [31:0] vel_r, vel_nxt;
  logic [31:0] phase_r, phase_nxt;
  logic [30:0] dt_r, dt_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [30:0] hi_r, hi_nxt;
  logic [25:0] carry_r, carry_nxt;
  logic [16:0] duty_r [0:2];
  logic [16:0] duty_nxt;
  logic        duty_we;

  logic        out_valid_r, out_valid_nxt;
  logic [16:0] out_u_r, out_v_r, out_w_r;
  logic        out_load;

  olr_pkg::mul_req_t mul_req;
  logic [63:0] mul_p;
  logic [31:0] phase_sel;
  logic [16:0] sine_biased;

  logic [31:0] diff;
  logic [48:0] amp_sum;
  logic [51:0] duty_p5;
  logic [18:0] duty_wide;
  logic [35:0] step_sum;

  olr_mul u_mul (
    .clk (clk),
    .req (mul_req),
    .p   (mul_p)
  );

  olr_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_sine (
    .clk    (clk),
    .phase  (phase_sel),
    .biased (sine_biased)
  );

  always_comb begin
    case (idx_r)
      2'd1:    phase_sel = phase_r - olr_pkg::THIRD_TURN;
      2'd2:    phase_sel = phase_r + olr_pkg::THIRD_TURN;
      default: phase_sel = phase_r;
    endcase
  end

  assign diff      = in_bus.now_us - (in_bus.hold ? in_bus.now_us : last_time_r);
  assign amp_sum   = 49'(amp_r) + 49'(mul_p[47:0]);
  assign duty_p5   = 52'(mul_p[48:0]) + {mul_p[49:0], 2'b00};
  assign duty_wide = duty_p5[51:33];
  assign step_sum  = mul_p[35:0] + 36'(carry_r);

  always_comb begin
    state_nxt     = state_r;
    last_time_nxt = last_time_r;
    amp_nxt       = amp_r;
    vel_nxt       = vel_r;
    phase_nxt     = phase_r;
    dt_nxt        = dt_r;
    idx_nxt       = idx_r;
    hi_nxt        = hi_r;
    carry_nxt     = carry_r;
    duty_nxt      = (|duty_wide[18:17]) ? olr_pkg::DUTY_MAX : duty_wide[16:0];
    duty_we       = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_bus.ready;
    mul_req       = '{en: 1'b0, a: vel_r, b: {1'b0, dt_r}};
    in_bus.ready  = 1'b0;

    case (state_r)
      olr_pkg::S_IDLE: begin
        in_bus.ready = 1'b1;
        if (in_bus.valid) begin
          last_time_nxt = in_bus.now_us;
          if (in_bus.hold) begin
            amp_nxt = '0;
          end
          dt_nxt    = diff[31] ? 31'(wrap_dt_r) : diff[30:0];
          state_nxt = olr_pkg::S_AMP_MUL;
        end
      end
      olr_pkg::S_AMP_MUL: begin
        mul_req   = '{en: 1'b1, a: 32'(amp_step_r), b: {1'b0, dt_r}};
        state_nxt = olr_pkg::S_AMP_SUM;
      end
      olr_pkg::S_AMP_SUM: begin
        amp_nxt   = (amp_sum > 49'(max_amp_r)) ? max_amp_r : amp_sum[31:0];
        idx_nxt   = 2'd0;
        state_nxt = olr_pkg::S_SIN_RD;
      end
      olr_pkg::S_SIN_RD: begin
        state_nxt = olr_pkg::S_SIN_MUL;
      end
      olr_pkg::S_SIN_MUL: begin
        mul_req   = '{en: 1'b1, a: amp_r, b: 32'(sine_biased)};
        state_nxt = olr_pkg::S_SIN_SCALE;
      end
      olr_pkg::S_SIN_SCALE: begin
        duty_we = 1'b1;
        if (idx_r == 2'd2) begin
          state_nxt = olr_pkg::S_VEL_MUL;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = olr_pkg::S_SIN_RD;
        end
      end
      olr_pkg::S_VEL_MUL: begin
        if (vel_r < {1'b0, top_vel_r}) begin
          mul_req   = '{en: 1'b1, a: vel_r, b: 32'(vel_growth_r)};
          state_nxt = olr_pkg::S_VEL_UPD;
        end else begin
          state_nxt = olr_pkg::S_PH_MUL1;
        end
      end
      olr_pkg::S_VEL_UPD: begin
        vel_nxt   = mul_p[48] ? 32'hFFFF_FFFF : mul_p[47:16];
        state_nxt = olr_pkg::S_PH_MUL1;
      end
      olr_pkg::S_PH_MUL1: begin
        mul_req   = '{en: 1'b1, a: vel_r, b: {1'b0, dt_r}};
        state_nxt = olr_pkg::S_PH_MUL2;
      end
      olr_pkg::S_PH_MUL2: begin
        hi_nxt    = mul_p[62:32];
        mul_req   = '{en: 1'b1, a: mul_p[31:0], b: olr_pkg::PHASE_GAIN};
        state_nxt = olr_pkg::S_PH_MUL3;
      end
      olr_pkg::S_PH_MUL3: begin
        carry_nxt = mul_p[57:32];
        mul_req   = '{en: 1'b1, a: {1'b0, hi_r}, b: olr_pkg::PHASE_GAIN};
        state_nxt = olr_pkg::S_PH_ADD;
      end
      olr_pkg::S_PH_ADD: begin
        phase_nxt = phase_r + step_sum[35:4];
        state_nxt = olr_pkg::S_OUT;
      end
      olr_pkg::S_OUT: begin
        if (!out_valid_r || out_bus.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = olr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = olr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olr_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      last_time_r <= '0;
      amp_r       <= '0;
      vel_r       <= olr_pkg::VELOCITY_RST;
      phase_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      last_time_r <= last_time_nxt;
      amp_r       <= amp_nxt;
      vel_r       <= vel_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dt_r    <= dt_nxt;
    hi_r    <= hi_nxt;
    carry_r <= carry_nxt;
    if (duty_we) begin
      duty_r[idx_r] <= duty_nxt;
    end
    if (out_load) begin
      out_u_r <= duty_r[0];
      out_v_r <= duty_r[1];
      out_w_r <= duty_r[2];
    end
  end

  // ramp registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_amp_r    <= olr_pkg::MAX_AMPLITUDE_RST;
      amp_step_r   <= olr_pkg::AMPLITUDE_STEP_RST;
      top_vel_r    <= olr_pkg::TOP_VELOCITY_RST;
      vel_growth_r <= olr_pkg::VELOCITY_GROWTH_RST;
      wrap_dt_r    <= olr_pkg::WRAP_DT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        olr_pkg::CFG_MAX_AMPLITUDE:   max_amp_r    <= cfg_wdata;
        olr_pkg::CFG_AMPLITUDE_STEP:  amp_step_r   <= cfg_wdata[15:0];
        olr_pkg::CFG_TOP_VELOCITY:    top_vel_r    <= cfg_wdata[30:0];
        olr_pkg::CFG_VELOCITY_GROWTH: vel_growth_r <= cfg_wdata[16:0];
        olr_pkg::CFG_WRAP_DT:         wrap_dt_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign out_bus.valid  = out_valid_r;
  assign out_bus.duty_u = out_u_r;
  assign out_bus.duty_v = out_v_r;
  assign out_bus.duty_w = out_w_r;

endmodule

// File: tb/tb_open_loop_three_phase_ramp.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_open_loop_three_phase_ramp
// Self-checking bench for the open-loop startup ramp. Timestamp beats go in
// through a valid/ready channel and every beat is predicted by a bit-exact
// model of the amplitude ramp, quarter-wave sine, speed growth and phase
// advance. Duty beats are checked field by field in order. A directed
// opening covers timestamp wrap, hold, clamp and register extremes, then
// random timestamp streams, with backward steps and jumps, run under several register settings
// and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_open_loop_three_phase_ramp;

  localparam int unsigned SINE_DEPTH = 256;
  localparam longint      Q30        = 64'sd1073741824;

  localparam int SET_RESET  = 0;
  localparam int SET_HIGH   = 1;
  localparam int SET_LOW    = 2;
  localparam int SET_RANDOM = 3;

  typedef struct packed {
    logic [16:0] u;
    logic [16:0] v;
    logic [16:0] w;
  } duties_t;

  class duty_scoreboard;
    bit [31:0]   max_amp, amp_step, top_vel, vel_growth, wrap_us;
    bit [31:0]   last_us, amp, vel, ph;
    int unsigned quarter_tbl[SINE_DEPTH+1];
    duties_t     pending_duties[$];
    int          errors;

    function new();
      for (int k = 0; k <= SINE_DEPTH; k++) quarter_tbl[k] = quarter_entry(k);
      max_amp    = olr_pkg::MAX_AMPLITUDE_RST;
      amp_step   = {16'b0, olr_pkg::AMPLITUDE_STEP_RST};
      top_vel    = {1'b0, olr_pkg::TOP_VELOCITY_RST};
      vel_growth = {15'b0, olr_pkg::VELOCITY_GROWTH_RST};
      wrap_us    = {16'b0, olr_pkg::WRAP_DT_RST};
      last_us    = '0;
      amp        = '0;
      vel        = olr_pkg::VELOCITY_RST;
      ph         = '0;
      errors     = 0;
    endfunction

    // odd polynomial in q30, rounded to q1.15
    function int unsigned quarter_entry(int unsigned k);
      longint t, s, r;
      t = (longint'(k) << 30) / longint'(SINE_DEPTH);
      s = (t * t) / Q30;
      r = -3864;
      r = 172270 + (r * s) / Q30;
      r = -5026990 + (r * s) / Q30;
      r = 85569310 + (r * s) / Q30;
      r = -693598670 + (r * s) / Q30;
      r = 1686629713 + (r * s) / Q30;
      r = (r * t) / Q30;
      if (r < 0) r = 0;
      r = (r + 16384) / 32768;
      if (r > 32768) r = 32768;
      return int'(r);
    endfunction

    function int sine_at(bit [31:0] p);
      bit [63:0]   f;
      int unsigned i, k;
      int          v;
      f = {34'b0, p[29:0]};
      i = 32'((f * SINE_DEPTH) >> 30);
      k = p[30] ? SINE_DEPTH - i : i;
      v = quarter_tbl[k];
      return p[31] ? -v : v;
    endfunction

    function bit [16:0] duty_at(bit [31:0] p);
      bit [63:0] biased, d;
      biased = 64'(sine_at(p) + 32768);
      d = (64'(amp) * biased * 64'd5) >> 33;
      return (d > 64'(olr_pkg::DUTY_MAX)) ? olr_pkg::DUTY_MAX : d[16:0];
    endfunction

    function void set_register(bit [olr_pkg::CFG_IDX_W-1:0] idx, bit [31:0] val);
      case (idx)
        olr_pkg::CFG_MAX_AMPLITUDE:   max_amp    = val;
        olr_pkg::CFG_AMPLITUDE_STEP:  amp_step   = {16'b0, val[15:0]};
        olr_pkg::CFG_TOP_VELOCITY:    top_vel    = {1'b0, val[30:0]};
        olr_pkg::CFG_VELOCITY_GROWTH: vel_growth = {15'b0, val[16:0]};
        olr_pkg::CFG_WRAP_DT:         wrap_us    = {16'b0, val[15:0]};
        default: ;
      endcase
    endfunction

    function void take_timestamp(bit [31:0] now_us, bit hold);
      bit [31:0] dt;
      bit [63:0] a, p, step;
      duties_t   d;
      if (hold) begin
        amp     = '0;
        last_us = now_us;
      end
      dt = now_us - last_us;
      if (dt[31]) dt = wrap_us;
      a = 64'(amp) + 64'(amp_step) * 64'(dt);
      if (a > 64'(max_amp)) a = 64'(max_amp);
      amp = a[31:0];
      d.u = duty_at(ph);
      d.v = duty_at(ph - olr_pkg::THIRD_TURN);
      d.w = duty_at(ph + olr_pkg::THIRD_TURN);
      pending_duties.push_back(d);
      last_us = now_us;
      if (vel < top_vel) begin
        a   = (64'(vel) * 64'(vel_growth)) >> 16;
        vel = (a > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : a[31:0];
      end
      p    = 64'(vel) * 64'(dt);
      step = ((p >> 32) * 64'(olr_pkg::PHASE_GAIN)
             + (((p & 64'hFFFF_FFFF) * 64'(olr_pkg::PHASE_GAIN)) >> 32)) >> 4;
      ph   = ph + step[31:0];
    endfunction

    function void check_duties(duties_t got);
      duties_t exp_d;
      if (pending_duties.size() == 0) begin
        errors++;
        $display("%0t: duty beat with none expected: u %0d v %0d w %0d",
                 $time, got.u, got.v, got.w);
        return;
      end
      exp_d = pending_duties.pop_front();
      if (got.u !== exp_d.u) begin
        errors++;
        $display("%0t: duty_u expected %0d actual %0d", $time, exp_d.u, got.u);
      end
      if (got.v !== exp_d.v) begin
        errors++;
        $display("%0t: duty_v expected %0d actual %0d", $time, exp_d.v, got.v);
      end
      if (got.w !== exp_d.w) begin
        errors++;
        $display("%0t: duty_w expected %0d actual %0d", $time, exp_d.w, got.w);
      end
    endfunction

    function int pending_count();
      return pending_duties.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [olr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [olr_pkg::CFG_DATA_W-1:0] cfg_wdata;

  olr_in_if  in_bus ();
  olr_out_if out_bus ();

  open_loop_three_phase_ramp #(
    .SINE_TABLE_DEPTH(SINE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  duty_scoreboard sb;
  bit [31:0]      prev_stamp;
  int             in_idle_pct;
  int             out_stall_pct;
  int             idle_in_tbl[4]  = '{0, 63, 0, 31};
  int             idle_out_tbl[4] = '{0, 0, 63, 31};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: ready toggles in runs of random length
  initial begin
    int      run;
    bit      stall;
    duties_t got;
    run = 0;
    stall = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        got.u = out_bus.duty_u;
        got.v = out_bus.duty_v;
        got.w = out_bus.duty_w;
        sb.check_duties(got);
      end
      @(negedge clk);
      if (run == 0) begin
        run   = $urandom_range(1, 24);
        stall = ($urandom_range(0, 99) < out_stall_pct);
      end
      run--;
      out_bus.ready = !stall;
    end
  end

  // all driving tasks start and end just after a falling edge
  task automatic send_beat(input bit [31:0] stamp_us, input bit hold_bit);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
    in_bus.valid  = 1'b1;
    in_bus.now_us = stamp_us;
    in_bus.hold   = hold_bit;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.take_timestamp(stamp_us, hold_bit);
    prev_stamp = stamp_us;
    @(negedge clk);
  endtask

  task automatic send_random_beat();
    bit [31:0] stamp;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) stamp = prev_stamp + $urandom_range(0, 200);
    else if (pick < 72) stamp = prev_stamp + $urandom_range(0, 70000);
    else if (pick < 80) stamp = prev_stamp - $urandom_range(1, 1000);
    else if (pick < 86) stamp = prev_stamp + $urandom;
    else if (pick < 92) stamp = $urandom;
    else begin
      case ($urandom_range(0, 3))
        0:       stamp = prev_stamp + 32'h7FFF_FFFF;
        1:       stamp = prev_stamp + 32'h8000_0000;
        2:       stamp = 32'h0000_0000;
        default: stamp = 32'hFFFF_FFFF;
      endcase
    end
    send_beat(stamp, $urandom_range(0, 15) == 0);
  endtask

  task automatic drain_results();
    in_bus.valid = 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input bit [olr_pkg::CFG_IDX_W-1:0] idx, input bit [31:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    sb.set_register(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic bit [31:0] cfg_value(olr_pkg::cfg_idx_t r, int kind);
    case (r)
      olr_pkg::CFG_MAX_AMPLITUDE:
        case (kind)
          SET_RESET: return olr_pkg::MAX_AMPLITUDE_RST;
          SET_HIGH:  return 32'hFFFF_FFFF;
          SET_LOW:   return 32'h0;
          default:   return $urandom;
        endcase
      olr_pkg::CFG_AMPLITUDE_STEP:
        case (kind)
          SET_RESET: return {16'b0, olr_pkg::AMPLITUDE_STEP_RST};
          SET_HIGH:  return 32'hFFFF;
          SET_LOW:   return 32'h0;
          default:   return $urandom_range(0, 65535);
        endcase
      olr_pkg::CFG_TOP_VELOCITY:
        case (kind)
          SET_RESET: return {1'b0, olr_pkg::TOP_VELOCITY_RST};
          SET_HIGH:  return 32'h7FFF_FFFF;
          SET_LOW:   return 32'h0;
          default:   return $urandom_range(0, 32'h7FFF_FFFF);
        endcase
      olr_pkg::CFG_VELOCITY_GROWTH:
        case (kind)
          SET_RESET: return {15'b0, olr_pkg::VELOCITY_GROWTH_RST};
          SET_HIGH:  return 32'h1_FFFF;
          SET_LOW:   return 32'h1_0000;
          default:   return $urandom_range(65536, 131071);
        endcase
      default:
        case (kind)
          SET_RESET: return {16'b0, olr_pkg::WRAP_DT_RST};
          SET_HIGH:  return 32'hFFFF;
          SET_LOW:   return 32'h0;
          default:   return $urandom_range(0, 65535);
        endcase
    endcase
  endfunction

  task automatic apply_settings(input int kind);
    for (int j = olr_pkg::CFG_MAX_AMPLITUDE; j <= olr_pkg::CFG_WRAP_DT; j++)
      write_reg(j[olr_pkg::CFG_IDX_W-1:0], cfg_value(olr_pkg::cfg_idx_t'(j), kind));
  endtask

  initial begin
    sb = new();
    rst_n         = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.now_us = '0;
    in_bus.hold   = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    prev_stamp    = '0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: zero dt, forward, backward, wrap, hold, huge dt
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'd1000, 1'b0);
    send_beat(32'd500, 1'b0);
    send_beat(32'h8000_1000, 1'b0);
    send_beat(32'hFFFF_FFFF, 1'b1);
    send_beat(32'h0000_0010, 1'b0);
    send_beat(32'h7FFF_FFFF, 1'b0);
    send_beat(32'h7FFF_FFFF, 1'b0);
    send_beat(32'h1234_5678, 1'b1);
    drain_results();

    // writes to unused indexes must not disturb anything
    for (int j = olr_pkg::CFG_WRAP_DT + 1; j < 2 ** olr_pkg::CFG_IDX_W; j++)
      write_reg(j[olr_pkg::CFG_IDX_W-1:0], $urandom);

    // top of every register: amplitude clamp near full scale, duty saturation
    apply_settings(SET_HIGH);
    send_beat(32'h0000_0000, 1'b1);
    send_beat(32'h0001_0000, 1'b0);
    send_beat(32'h0002_0000, 1'b0);
    send_beat(32'h0001_0000, 1'b0);
    send_beat(32'h0003_0000, 1'b0);
    send_beat(32'h0004_2345, 1'b0);
    send_beat(32'h0009_0000, 1'b0);
    send_beat(32'h000A_0000, 1'b0);
    drain_results();

    // bottom of every register
    apply_settings(SET_LOW);
    send_beat(32'd5, 1'b0);
    send_beat(32'd3, 1'b0);
    send_beat(32'hFFFF_FFFF, 1'b1);
    send_beat(32'h0000_0000, 1'b0);

    for (int p = 0; p < 8; p++) begin
      drain_results();
      apply_settings(p % 4);
      in_idle_pct   = idle_in_tbl[p / 2];
      out_stall_pct = idle_out_tbl[p / 2];
      repeat (81) begin
        if ($urandom_range(0, 39) == 0) drain_results();
        send_random_beat();
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: open_loop_three_phase_ramp.f
hdl/olr_pkg.sv
hdl/olr_if.sv
hdl/olr_mul.sv
hdl/olr_sine_rom.sv
hdl/open_loop_three_phase_ramp.sv
tb/tb_open_loop_three_phase_ramp.sv
